// File: hw/rtl/irt_pkg.sv
// Shared types and constants for the interval reservation table.
// No dependencies; imported by every other source file.
package irt_pkg;

    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int FIELD_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((STATUS_W + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_W-1:0]     count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    // per-cell update command from the top level
    typedef struct packed {
        logic ins;    // load the request
        logic shift;  // load the neighbor below
    } cell_ctl_t;

    // per-cell compare result, registered in the cell
    typedef struct packed {
        logic dec;    // this entry decides the scan
        logic left;   // request lies left of it (or cell holds no entry)
    } cell_flag_t;

endpackage

// File: hw/rtl/irt_cell.sv
// One slot of the interval table: holds one interval, compares it with a
// request, and shifts up from its lower neighbor on insert. Uses irt_pkg.
module irt_cell (
    input  logic               aclk,
    input  logic               cmp_en,
    input  irt_pkg::time_t     req_start,
    input  irt_pkg::time_t     req_end,
    input  logic               occ,
    input  logic               at_end,
    input  irt_pkg::cell_ctl_t ctl,
    input  irt_pkg::time_t     nb_start,
    input  irt_pkg::time_t     nb_end,
    output irt_pkg::time_t     slot_start,
    output irt_pkg::time_t     slot_end,
    output irt_pkg::cell_flag_t flag
);
    import irt_pkg::*;

    time_t      start_reg;
    time_t      end_reg;
    cell_flag_t flag_reg;
    cell_flag_t flag_next;
    logic       lt;
    logic       rt;

    always_comb begin
        lt = (req_end <= start_reg);
        rt = (req_start >= end_reg);
        if (occ) begin
            flag_next.dec  = lt | ~rt;
            flag_next.left = lt;
        end else begin
            flag_next.dec  = at_end;
            flag_next.left = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            flag_reg <= flag_next;
        end
        if (ctl.ins) begin
            start_reg <= req_start;
            end_reg   <= req_end;
        end else if (ctl.shift) begin
            start_reg <= nb_start;
            end_reg   <= nb_end;
        end
    end

    assign slot_start = start_reg;
    assign slot_end   = end_reg;
    assign flag       = flag_reg;

endmodule

// File: hw/rtl/interval_reservation_table.sv
// Top level of the interval reservation table: row of irt_cell slots,
// priority pick of the insertion slot, handshake and result register. Uses irt_pkg.
//
// Stores up to CAPACITY non-overlapping half-open intervals [start, end),
// kept sorted by start in a row of cells. Each request word gets one result
// word: ST_OK (stored), ST_OVERLAP (first deciding entry overlaps) or
// ST_FULL (table already holds CAPACITY entries). In the accept cycle all
// cells compare the request against their entry in parallel and register a
// decide/left flag; in the update state one 64-bit find-first-set over the
// flags picks the insertion slot, cells at and above it shift up by one, and
// the status is loaded into the result register. The update waits while a
// previous result is still held, and no request is accepted until it is done.
// Slot contents have no reset; only state, fill count and output valid are cleared.
module interval_reservation_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [irt_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] req_start, [63:32] req_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [irt_pkg::M_DATA_W-1:0] m_tdata   // [1:0] status, rest zero
);
    import irt_pkg::*;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    time_t   rs_reg, re_reg;
    logic    m_valid_reg, m_valid_next;
    status_t status_reg, status_next;

    logic    accept;
    logic    fire;        // update cycle may commit
    logic    commit;      // insert takes place
    logic    is_full;
    logic    overlap;
    time_t   in_start, in_end;

    logic [CAPACITY-1:0] dec_v, left_v, first_v, below_v, occ_v, end_v;
    cell_ctl_t  ctl   [CAPACITY];
    cell_flag_t flag  [CAPACITY];
    time_t      c_start [CAPACITY];
    time_t      c_end   [CAPACITY];

    assign in_start = s_tdata[TIME_BITS-1:0];
    assign in_end   = s_tdata[FIELD_W+TIME_BITS-1:FIELD_W];

    assign accept = s_tvalid & s_tready;
    assign fire   = (state_reg == S_UPD) & (~m_valid_reg | m_tready);
    assign is_full = (count_reg == count_t'(CAPACITY));

    // find first deciding cell; the table-end cell always decides when not full
    assign first_v = dec_v & (~dec_v + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign below_v = first_v - {{(CAPACITY-1){1'b0}}, 1'b1};
    assign overlap = |(first_v & ~left_v);
    assign commit  = fire & ~is_full & ~overlap;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            assign occ_v[k]  = (count_t'(k) < count_reg);
            assign end_v[k]  = (count_t'(k) == count_reg);
            assign dec_v[k]  = flag[k].dec;
            assign left_v[k] = flag[k].left;
            assign ctl[k].ins   = commit & first_v[k];
            assign ctl[k].shift = commit & ~first_v[k] & ~below_v[k];

            if (k == 0) begin : g_bottom
                irt_cell u_cell (
                    .aclk       (aclk),
                    .cmp_en     (accept),
                    .req_start  (accept ? in_start : rs_reg),
                    .req_end    (accept ? in_end : re_reg),
                    .occ        (occ_v[k]),
                    .at_end     (end_v[k]),
                    .ctl        (ctl[k]),
                    .nb_start   ('0),
                    .nb_end     ('0),
                    .slot_start (c_start[k]),
                    .slot_end   (c_end[k]),
                    .flag       (flag[k])
                );
            end else begin : g_upper
                irt_cell u_cell (
                    .aclk       (aclk),
                    .cmp_en     (accept),
                    .req_start  (accept ? in_start : rs_reg),
                    .req_end    (accept ? in_end : re_reg),
                    .occ        (occ_v[k]),
                    .at_end     (end_v[k]),
                    .ctl        (ctl[k]),
                    .nb_start   (c_start[k-1]),
                    .nb_end     (c_end[k-1]),
                    .slot_start (c_start[k]),
                    .slot_end   (c_end[k]),
                    .flag       (flag[k])
                );
            end
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        count_next   = count_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        status_next  = status_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            priority if (is_full) begin
                status_next = ST_FULL;
            end else if (overlap) begin
                status_next = ST_OVERLAP;
            end else begin
                status_next = ST_OK;
                count_next  = count_reg + count_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            rs_reg <= in_start;
            re_reg <= in_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-STATUS_W){1'b0}}, status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(CAPACITY))
        else $error("fill count above capacity");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((status_reg == ST_OK) || (status_reg == ST_OVERLAP)
                         || (status_reg == ST_FULL)))
        else $error("undefined status code");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (count_reg == $past(count_reg) + count_t'(1)))
        else $error("fill count not advanced on insert");

    a_one_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> $onehot(first_v) || is_full)
        else $error("no unique insertion slot");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> !accept)
        else $error("request taken during update");

endmodule

// File: verif/irt_checker.sv
// Checker for the interval reservation table: keeps its own copy of the stored
// intervals, predicts the status word of every request and checks the result channel.
// Depends on irt_pkg; watches the ports only.
module irt_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [irt_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] req_start, [63:32] req_end
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [irt_pkg::M_DATA_W-1:0] m_tdata,   // [1:0] status, rest zero
    output int                           mismatch_count,
    output int                           status_pending,
    output int                           n_stored,
    output int                           n_overlap,
    output int                           n_full
);
    import irt_pkg::*;

    time_t   held_start [CAPACITY];
    time_t   held_end   [CAPACITY];
    int      held_count;
    status_t status_due [$];

    // linear scan from the lowest slot; first deciding entry wins
    function automatic status_t reserve_interval(time_t lo, time_t hi);
        int slot;
        slot = held_count;
        if (held_count >= CAPACITY)
            return ST_FULL;
        for (int k = 0; k < held_count; k++) begin
            if (hi <= held_start[k]) begin
                slot = k;
                break;
            end
            if (lo < held_end[k])
                return ST_OVERLAP;
        end
        for (int k = held_count; k > slot; k--) begin
            held_start[k] = held_start[k-1];
            held_end[k]   = held_end[k-1];
        end
        held_start[slot] = lo;
        held_end[slot]   = hi;
        held_count++;
        return ST_OK;
    endfunction

    always @(posedge aclk) begin
        status_t             want;
        logic [M_DATA_W-1:0] want_word;
        if (!aresetn) begin
            held_count = 0;
            status_due.delete();
        end else begin
            // results first: a result at this edge belongs to an earlier request
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("irt_checker: result word %0h with no request pending",
                                 m_tdata);
                    mismatch_count++;
                end else begin
                    want      = status_due.pop_front();
                    want_word = M_DATA_W'(want);
                    if (m_tdata !== want_word) begin
                        if (mismatch_count < 10)
                            $display("irt_checker: status expected %0d (%s), got word %0h",
                                     want, want.name(), m_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = reserve_interval(s_tdata[FIELD_W-1:0],
                                        s_tdata[2*FIELD_W-1:FIELD_W]);
                status_due = {status_due, want};
                case (want)
                    ST_OK:      n_stored++;
                    ST_OVERLAP: n_overlap++;
                    default:    n_full++;
                endcase
            end
        end
        status_pending = status_due.size();
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the interval reservation table: clock, reset, request and
// result traffic with random idling, watchdog and verdict.
// Depends on irt_pkg, interval_reservation_table and irt_checker.
module tb_top;
    import irt_pkg::*;

    localparam int N_RANDOM   = 680;
    localparam int CHUNK      = 100;
    localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [31:0] req_start, [63:32] req_end
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [1:0] status, rest zero

    int mismatch_count;
    int status_pending;
    int n_stored;
    int n_overlap;
    int n_full;
    int quiet_cycles;

    // idling switches, changed per chunk of random traffic
    logic s_quiet;
    logic m_quiet;

    interval_reservation_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    irt_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .status_pending (status_pending),
        .n_stored       (n_stored),
        .n_overlap      (n_overlap),
        .n_full         (n_full)
    );

    always #2 aclk = ~aclk;

    // watchdog: a hang shows up as a long run of cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: watchdog, %0d results still due", status_pending);
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: per word, a random stall before taking it unless m_quiet is set
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = m_quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // one request word; entered and left at a falling edge
    task automatic send_req(input time_t lo, input time_t hi);
        int gap;
        gap = s_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // hold off until every status word has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (status_pending != 0) @(negedge aclk);
    endtask

    // Requests cluster in four 4K windows spread over the 32-bit range so
    // that overlaps, touching edges and gap fills are common and the table
    // fills gradually; a few wide random and inverted requests on top.
    function automatic void draw_request(output time_t lo, output time_t hi);
        time_t origin;
        int    pick;
        case ($urandom_range(0, 3))
            0:       origin = 32'h0000_0000;
            1:       origin = 32'h5555_0000;
            2:       origin = 32'hAAAA_0000;
            default: origin = 32'hFFFF_F000;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            lo = $urandom;
            hi = $urandom;
        end else if (pick < 10) begin
            // empty or inverted
            lo = origin + $urandom_range(0, 4095);
            hi = lo - $urandom_range(0, 64);
        end else if (pick < 20) begin
            // narrow, fits leftover gaps
            lo = origin + $urandom_range(0, 4095);
            hi = lo + $urandom_range(1, 8);
        end else if (pick < 60) begin
            // grid aligned, so edges touch often
            lo = origin + 64 * $urandom_range(0, 63);
            hi = lo + 64 * $urandom_range(1, 8);
        end else begin
            lo = origin + $urandom_range(0, 4095);
            hi = lo + $urandom_range(1, 600);
        end
    endfunction

    initial begin
        time_t lo;
        time_t hi;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        s_quiet      = 1'b0;
        m_quiet      = 1'b0;
        quiet_cycles = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty table, touching edges on both sides, overlaps,
        // empty and inverted requests, range extremes
        send_req(32'd100, 32'd200);
        send_req(32'd200, 32'd300);
        send_req(32'd50, 32'd100);
        send_req(32'd150, 32'd250);
        send_req(32'd199, 32'd201);
        send_req(32'd300, 32'd300);
        send_req(32'd0, 32'd0);
        send_req(32'd0, 32'd0);
        send_req(32'd400, 32'd350);
        send_req(32'd20, 32'd10);
        send_req(32'hFFFF_FFFF, 32'd0);
        send_req(32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_req(32'd0, 32'hFFFF_FFFF);
        send_req(32'h8000_0000, 32'h8000_0001);
        send_req(32'h7FFF_FFFF, 32'h8000_0001);
        send_req(32'h5555_5555, 32'hAAAA_AAAA);
        send_req(32'hAAAA_AAAA, 32'h5555_5555);
        send_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_req(32'd99, 32'd101);
        drain();

        // random traffic in chunks, each with its own idling mix; every
        // other chunk ends with the sender held off until all status is back
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % CHUNK == 0) begin
                case ($urandom_range(0, 3))
                    0:       begin s_quiet = 1'b0; m_quiet = 1'b0; end
                    1:       begin s_quiet = 1'b1; m_quiet = 1'b1; end
                    2:       begin s_quiet = 1'b0; m_quiet = 1'b1; end
                    default: begin s_quiet = 1'b1; m_quiet = 1'b0; end
                endcase
                if ((i / CHUNK) % 2 == 1)
                    drain();
            end
            draw_request(lo, hi);
            send_req(lo, hi);
        end

        drain();
        repeat (20) @(negedge aclk);
        $display("tb_top: %0d requests, %0d stored, %0d overlapping, %0d refused as full",
                 n_stored + n_overlap + n_full, n_stored, n_overlap, n_full);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: %0d mismatches", mismatch_count);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/irt_pkg.sv
hw/rtl/irt_cell.sv
hw/rtl/interval_reservation_table.sv
verif/irt_checker.sv
verif/tb_top.sv
